// ===== hdl/ild_pkg.sv =====
// Shared types, codes and decode helpers for the instruction length decoder.
package ild_pkg;

	localparam logic [2:0] PH_PREFIX  = 3'd0;
	localparam logic [2:0] PH_OPCODE2 = 3'd1;
	localparam logic [2:0] PH_MODRM   = 3'd2;
	localparam logic [2:0] PH_SIB     = 3'd3;
	localparam logic [2:0] PH_DISP    = 3'd4;
	localparam logic [2:0] PH_IMM     = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;

	localparam int FB_MODRM  = 0;
	localparam int FB_SIB    = 1;
	localparam int FB_DISP8  = 2;
	localparam int FB_DISP32 = 3;
	localparam int FB_IMM8   = 4;
	localparam int FB_IMM32  = 5;
	localparam int FB_IMM64  = 6;
	localparam int FB_ERROR  = 7;

	localparam logic [4:0] MAX_PREFIXES = 5'd15;

	localparam logic [7:0] OP_ESCAPE = 8'h0F;
	localparam logic [7:0] PFX_REPE  = 8'hF3;
	localparam logic [7:0] PFX_REPNE = 8'hF2;
	localparam logic [7:0] PFX_LOCK  = 8'hF0;
	localparam logic [7:0] PFX_OPSZ  = 8'h66;
	localparam logic [7:0] PFX_ADSZ  = 8'h67;
	localparam logic [7:0] PFX_ES    = 8'h26;
	localparam logic [7:0] PFX_CS    = 8'h2E;
	localparam logic [7:0] PFX_SS    = 8'h36;
	localparam logic [7:0] PFX_DS    = 8'h3E;
	localparam logic [7:0] PFX_FS    = 8'h64;
	localparam logic [7:0] PFX_GS    = 8'h65;

	localparam logic [7:0] OP_RM_A_LO     = 8'h80;
	localparam logic [7:0] OP_RM_A_HI     = 8'h8F;
	localparam logic [7:0] OP_RM_B_LO     = 8'hC0;
	localparam logic [7:0] OP_RM_B_HI     = 8'hDF;
	localparam logic [7:0] OP_GRP3_B      = 8'hF6;
	localparam logic [7:0] OP_GRP3_V      = 8'hF7;
	localparam logic [7:0] OP_GRP4        = 8'hFE;
	localparam logic [7:0] OP_GRP5        = 8'hFF;
	localparam logic [7:0] OP_ALU_LIMIT   = 8'h40;
	localparam logic [2:0] ALU_IMM_ROW    = 3'd5;
	localparam logic [7:0] OP_PUSH_IMM32  = 8'h68;
	localparam logic [7:0] OP_PUSH_IMM8   = 8'h6A;
	localparam logic [7:0] OP_IMUL_IMM8   = 8'h6B;
	localparam logic [7:0] OP_GRP1_IMM8   = 8'h83;
	localparam logic [7:0] OP_MOV_IMM_LO  = 8'hB8;
	localparam logic [7:0] OP_MOV_IMM_HI  = 8'hBF;
	localparam logic [7:0] OP2_IMM32 [0:3] = '{8'h6C, 8'h6D, 8'hA9, 8'hAB};

	localparam logic [1:0] MOD_MEM     = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP32  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;
	localparam logic [2:0] RM_SIB      = 3'd4;
	localparam logic [2:0] RM_DISP32   = 3'd5;

	typedef struct packed {
		logic [2:0]  phase;
		logic [4:0]  byte_count;
		logic [3:0]  left;
		logic [7:0]  rep;
		logic [7:0]  segment;
		logic [2:0]  prefix_bits;
		logic [7:0]  opcode;
		logic [7:0]  opcode2;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [63:0] imm;
		logic [7:0]  flags;
	} ild_state_t;

	typedef struct packed {
		logic [4:0]  inst_length;
		logic [7:0]  field_flags;
		logic [7:0]  rep_prefix;
		logic [7:0]  segment_prefix;
		logic [2:0]  other_prefixes;
		logic [7:0]  primary_opcode;
		logic [7:0]  secondary_opcode;
		logic [7:0]  modrm_byte;
		logic [7:0]  sib_byte;
		logic [31:0] displacement;
		logic [63:0] immediate;
	} ild_result_t;

	function automatic logic takes_modrm(input logic [7:0] op);
		return (op inside {[OP_RM_A_LO:OP_RM_A_HI], [OP_RM_B_LO:OP_RM_B_HI],
			OP_GRP3_B, OP_GRP3_V, OP_GRP4, OP_GRP5, OP_ESCAPE});
	endfunction

	function automatic logic alu_imm32(input logic [7:0] op);
		return (op < OP_ALU_LIMIT) && (op[2:0] == ALU_IMM_ROW);
	endfunction

	// Pick the first field still needed from the given phase onward.
	function automatic ild_state_t plan_from(input logic [2:0] stage, input ild_state_t s);
		ild_state_t r;
		logic [1:0] md;
		logic [2:0] rm;
		logic have;
		r = s;
		md = s.modrm[7:6];
		rm = s.modrm[2:0];
		have = s.flags[FB_MODRM];
		r.phase = PH_DONE;
		if (stage <= PH_MODRM && takes_modrm(s.opcode)) begin
			r.flags[FB_MODRM] = 1'b1;
			r.phase = PH_MODRM;
		end else if (stage <= PH_SIB && have && md != MOD_REG && rm == RM_SIB) begin
			r.flags[FB_SIB] = 1'b1;
			r.phase = PH_SIB;
		end else if (stage <= PH_DISP && have &&
		             ((md == MOD_MEM && rm == RM_DISP32) || md == MOD_DISP32)) begin
			r.flags[FB_DISP32] = 1'b1;
			r.left = 4'd4;
			r.phase = PH_DISP;
		end else if (stage <= PH_DISP && have && md == MOD_DISP8) begin
			r.flags[FB_DISP8] = 1'b1;
			r.left = 4'd1;
			r.phase = PH_DISP;
		end else if (stage <= PH_IMM) begin
			if (s.opcode == OP_ESCAPE) begin
				if (alu_imm32(s.opcode2) ||
				    (s.opcode2 inside {OP2_IMM32[0], OP2_IMM32[1], OP2_IMM32[2],
				                       OP2_IMM32[3]})) begin
					r.flags[FB_IMM32] = 1'b1;
					r.left = 4'd4;
					r.phase = PH_IMM;
				end
			end else if (alu_imm32(s.opcode) || s.opcode == OP_PUSH_IMM32) begin
				r.flags[FB_IMM32] = 1'b1;
				r.left = 4'd4;
				r.phase = PH_IMM;
			end else if (s.opcode inside {OP_PUSH_IMM8, OP_IMUL_IMM8, OP_GRP1_IMM8}) begin
				r.flags[FB_IMM8] = 1'b1;
				r.left = 4'd1;
				r.phase = PH_IMM;
			end else if (s.opcode inside {[OP_MOV_IMM_LO:OP_MOV_IMM_HI]}) begin
				if (s.prefix_bits[1]) begin
					r.flags[FB_IMM32] = 1'b1;
					r.left = 4'd4;
				end else begin
					r.flags[FB_IMM64] = 1'b1;
					r.left = 4'd8;
				end
				r.phase = PH_IMM;
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/ild_step.sv =====
// Next-state and result logic for one code byte of the length decoder.
module ild_step import ild_pkg::*; (
	input  ild_state_t  cur,
	input  logic [7:0]  code_byte,
	output ild_state_t  nxt,
	output logic        done,
	output ild_result_t res
);

	ild_state_t s;
	logic [2:0] dtotal;
	logic [3:0] dleft;
	logic [1:0] didx;
	logic [3:0] itotal;
	logic [3:0] ileft;
	logic [2:0] iidx;
	logic [3:0] dsum;
	logic [3:0] isum;

	always_comb begin
		s = cur;
		s.byte_count = cur.byte_count + 5'd1;

		dtotal = cur.flags[FB_DISP8] ? 3'd1 : 3'd4;
		dleft = (cur.left == 4'd0 || cur.left > {1'b0, dtotal}) ? {1'b0, dtotal} : cur.left;
		dsum = {1'b0, dtotal} - dleft;
		didx = dsum[1:0];

		itotal = cur.flags[FB_IMM8] ? 4'd1 : (cur.flags[FB_IMM32] ? 4'd4 : 4'd8);
		ileft = (cur.left == 4'd0 || cur.left > itotal) ? itotal : cur.left;
		isum = itotal - ileft;
		iidx = isum[2:0];

		case (cur.phase)
			PH_OPCODE2: begin
				s.opcode2 = code_byte;
				s = plan_from(PH_MODRM, s);
			end
			PH_MODRM: begin
				s.modrm = code_byte;
				s = plan_from(PH_SIB, s);
			end
			PH_SIB: begin
				s.sib = code_byte;
				s = plan_from(PH_DISP, s);
			end
			PH_DISP: begin
				s.disp = cur.disp | ({24'd0, code_byte} << {didx, 3'b000});
				s.left = dleft - 4'd1;
				if (s.left == 4'd0) begin
					s = plan_from(PH_IMM, s);
				end
			end
			PH_IMM: begin
				s.imm = cur.imm | ({56'd0, code_byte} << {iidx, 3'b000});
				s.left = ileft - 4'd1;
				if (s.left == 4'd0) begin
					s.phase = PH_DONE;
				end
			end
			default: begin
				s.phase = PH_PREFIX;
				if (code_byte == PFX_REPE || code_byte == PFX_REPNE) begin
					s.rep = code_byte;
				end else if (code_byte == PFX_LOCK) begin
					s.prefix_bits[0] = 1'b1;
				end else if (code_byte inside {PFX_CS, PFX_SS, PFX_DS, PFX_ES, PFX_FS,
				                               PFX_GS}) begin
					s.segment = code_byte;
				end else if (code_byte == PFX_OPSZ) begin
					s.prefix_bits[1] = 1'b1;
				end else if (code_byte == PFX_ADSZ) begin
					s.prefix_bits[2] = 1'b1;
				end else begin
					s.opcode = code_byte;
					if (code_byte == OP_ESCAPE) begin
						s.phase = PH_OPCODE2;
					end else begin
						s = plan_from(PH_MODRM, s);
					end
				end
				if (s.phase == PH_PREFIX && s.byte_count > MAX_PREFIXES) begin
					s.flags = 8'd0;
					s.flags[FB_ERROR] = 1'b1;
					s.phase = PH_DONE;
				end
			end
		endcase

		done = (s.phase == PH_DONE);
		nxt = done ? '0 : s;

		res.inst_length      = s.byte_count;
		res.field_flags      = s.flags;
		res.rep_prefix       = s.rep;
		res.segment_prefix   = s.segment;
		res.other_prefixes   = s.prefix_bits;
		res.primary_opcode   = s.opcode;
		res.secondary_opcode = s.opcode2;
		res.modrm_byte       = s.modrm;
		res.sib_byte         = s.sib;
		res.displacement     = s.disp;
		res.immediate        = s.imm;
	end

endmodule

// ===== hdl/x86_64_instruction_length_decoder_unit.sv =====
// Top level of the x86-64 instruction length decoder.
//
//   channel   handshake                 payload
//   code      code_valid / code_ready   code_byte
//   inst      inst_valid / inst_ready   inst_length .. immediate
//
// One code byte per cycle, unless a stalled result holds the input. A byte is
// held in the input register, then the decode step updates the parse state and,
// on the last byte of an instruction, loads the result register. Reset clears the
// parse state and both valid flags. A stalled result blocks the byte that
// completes the next instruction and those behind it; earlier bytes keep flowing.
module x86_64_instruction_length_decoder_unit import ild_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_valid,
	output logic        code_ready,
	input  logic [7:0]  code_byte,
	output logic        inst_valid,
	input  logic        inst_ready,
	output logic [4:0]  inst_length,
	output logic [7:0]  field_flags,
	output logic [7:0]  rep_prefix,
	output logic [7:0]  segment_prefix,
	output logic [2:0]  other_prefixes,
	output logic [7:0]  primary_opcode,
	output logic [7:0]  secondary_opcode,
	output logic [7:0]  modrm_byte,
	output logic [7:0]  sib_byte,
	output logic [31:0] displacement,
	output logic [63:0] immediate
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	ild_state_t  state_q;
	ild_state_t  state_nxt;
	logic        done;
	ild_result_t res;
	logic        res_valid_q;
	ild_result_t res_q;
	logic        advance;

	ild_step u_step (
		.cur       (state_q),
		.code_byte (byte_s1),
		.nxt       (state_nxt),
		.done      (done),
		.res       (res)
	);

	assign advance = valid_s1 && (!done || !res_valid_q || inst_ready);
	assign code_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ready) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_ready && code_valid) begin
			byte_s1 <= code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && done) begin
			res_valid_q <= 1'b1;
		end else if (inst_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			res_q <= res;
		end
	end

	assign inst_valid       = res_valid_q;
	assign inst_length      = res_q.inst_length;
	assign field_flags      = res_q.field_flags;
	assign rep_prefix       = res_q.rep_prefix;
	assign segment_prefix   = res_q.segment_prefix;
	assign other_prefixes   = res_q.other_prefixes;
	assign primary_opcode   = res_q.primary_opcode;
	assign secondary_opcode = res_q.secondary_opcode;
	assign modrm_byte       = res_q.modrm_byte;
	assign sib_byte         = res_q.sib_byte;
	assign displacement     = res_q.displacement;
	assign immediate        = res_q.immediate;

endmodule

// ===== hdl/ild_check.sv =====
// Port-level checker for the length decoder, bound to the top level.
module ild_check (
	input logic        clk,
	input logic        arst_n,
	input logic        inst_valid,
	input logic        inst_ready,
	input logic [4:0]  inst_length,
	input logic [7:0]  field_flags,
	input logic [7:0]  primary_opcode,
	input logic [63:0] immediate
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		inst_valid && !inst_ready |=> inst_valid && $stable(inst_length) && $stable(field_flags))
		else $error("result transaction changed while stalled");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		inst_valid |-> inst_length != 5'd0 && inst_length <= 5'd27)
		else $error("instruction length out of range");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		inst_valid && field_flags[7] |-> inst_length == 5'd16 && field_flags[6:0] == 7'd0
		&& primary_opcode == 8'd0 && immediate == 64'd0)
		else $error("prefix overflow result malformed");

	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		inst_valid |-> $onehot0(field_flags[3:2]) && $onehot0(field_flags[6:4]))
		else $error("conflicting field size flags");

endmodule

bind x86_64_instruction_length_decoder_unit ild_check u_ild_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.inst_valid     (inst_valid),
	.inst_ready     (inst_ready),
	.inst_length    (inst_length),
	.field_flags    (field_flags),
	.primary_opcode (primary_opcode),
	.immediate      (immediate)
);

// ===== tb/x86_64_instruction_length_decoder_unit_tb.sv =====
// Self-checking testbench for the x86-64 instruction length decoder unit.
`timescale 1ns / 100ps

module x86_64_instruction_length_decoder_unit_tb;
	import ild_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES_PER_PHASE = 165;
	localparam int SEND_IDLE_PCT [0:3] = '{0, 71, 0, 22};
	localparam int RECV_STALL_PCT [0:3] = '{0, 0, 71, 22};

	localparam logic [7:0] PREFIX_SET [0:10] = '{PFX_REPE, PFX_REPNE, PFX_LOCK, PFX_ES,
		PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSZ, PFX_ADSZ};

	class ild_scoreboard;
		logic [2:0]  phase;
		logic [4:0]  count;
		logic [3:0]  left;
		logic [7:0]  rep;
		logic [7:0]  seg;
		logic [2:0]  pfx;
		logic [7:0]  op;
		logic [7:0]  op2;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [63:0] imm;
		logic [7:0]  flags;
		ild_result_t expected_q[$];
		int mismatches;
		int checked;
		int overflow_insts;
		int longest;

		function new();
			clear();
			mismatches = 0;
			checked = 0;
			overflow_insts = 0;
			longest = 0;
		endfunction

		function void clear();
			phase = PH_PREFIX;
			count = '0;
			left = '0;
			rep = '0;
			seg = '0;
			pfx = '0;
			op = '0;
			op2 = '0;
			modrm = '0;
			sib = '0;
			disp = '0;
			imm = '0;
			flags = '0;
		endfunction

		function bit needs_modrm(input logic [7:0] o);
			return (o >= OP_RM_A_LO && o <= OP_RM_A_HI) || (o >= OP_RM_B_LO && o <= OP_RM_B_HI) ||
				o == OP_GRP3_B || o == OP_GRP3_V || o == OP_GRP4 || o == OP_GRP5 ||
				o == OP_ESCAPE;
		endfunction

		function bit alu_form(input logic [7:0] o);
			return o < OP_ALU_LIMIT && o[2:0] == ALU_IMM_ROW;
		endfunction

		// Choose the next field to collect, starting at the given stage.
		function logic [2:0] plan(input logic [2:0] stage);
			logic [1:0] md;
			logic [2:0] rm;
			bit have;
			md = modrm[7:6];
			rm = modrm[2:0];
			have = flags[FB_MODRM];
			if (stage <= PH_MODRM && needs_modrm(op)) begin
				flags[FB_MODRM] = 1'b1;
				return PH_MODRM;
			end
			if (stage <= PH_SIB && have && md != MOD_REG && rm == RM_SIB) begin
				flags[FB_SIB] = 1'b1;
				return PH_SIB;
			end
			if (stage <= PH_DISP && have) begin
				if ((md == MOD_MEM && rm == RM_DISP32) || md == MOD_DISP32) begin
					flags[FB_DISP32] = 1'b1;
					left = 4'd4;
					return PH_DISP;
				end
				if (md == MOD_DISP8) begin
					flags[FB_DISP8] = 1'b1;
					left = 4'd1;
					return PH_DISP;
				end
			end
			if (stage <= PH_IMM) begin
				if (op == OP_ESCAPE) begin
					if (alu_form(op2) || op2 == OP2_IMM32[0] || op2 == OP2_IMM32[1] ||
					    op2 == OP2_IMM32[2] || op2 == OP2_IMM32[3]) begin
						flags[FB_IMM32] = 1'b1;
						left = 4'd4;
						return PH_IMM;
					end
				end else if (alu_form(op) || op == OP_PUSH_IMM32) begin
					flags[FB_IMM32] = 1'b1;
					left = 4'd4;
					return PH_IMM;
				end else if (op == OP_PUSH_IMM8 || op == OP_IMUL_IMM8 || op == OP_GRP1_IMM8) begin
					flags[FB_IMM8] = 1'b1;
					left = 4'd1;
					return PH_IMM;
				end else if (op >= OP_MOV_IMM_LO && op <= OP_MOV_IMM_HI) begin
					if (pfx[1]) begin
						flags[FB_IMM32] = 1'b1;
						left = 4'd4;
					end else begin
						flags[FB_IMM64] = 1'b1;
						left = 4'd8;
					end
					return PH_IMM;
				end
			end
			return PH_DONE;
		endfunction

		// Advance the length decode by one code byte; return 1 on a completed instruction.
		function bit step(input logic [7:0] b, output ild_result_t r);
			logic [3:0] span;
			logic [3:0] at;
			r = '0;
			count = count + 5'd1;
			case (phase)
				PH_OPCODE2: begin
					op2 = b;
					phase = plan(PH_MODRM);
				end
				PH_MODRM: begin
					modrm = b;
					phase = plan(PH_SIB);
				end
				PH_SIB: begin
					sib = b;
					phase = plan(PH_DISP);
				end
				PH_DISP: begin
					span = flags[FB_DISP8] ? 4'd1 : 4'd4;
					if (left == 4'd0 || left > span)
						left = span;
					at = span - left;
					disp = disp | (32'(b) << (8 * at[1:0]));
					left = left - 4'd1;
					if (left == 4'd0)
						phase = plan(PH_IMM);
				end
				PH_IMM: begin
					span = flags[FB_IMM8] ? 4'd1 : (flags[FB_IMM32] ? 4'd4 : 4'd8);
					if (left == 4'd0 || left > span)
						left = span;
					at = span - left;
					imm = imm | (64'(b) << (8 * at[2:0]));
					left = left - 4'd1;
					if (left == 4'd0)
						phase = PH_DONE;
				end
				default: begin
					phase = PH_PREFIX;
					if (b == PFX_REPE || b == PFX_REPNE)
						rep = b;
					else if (b == PFX_LOCK)
						pfx[0] = 1'b1;
					else if (b == PFX_ES || b == PFX_CS || b == PFX_SS || b == PFX_DS ||
					         b == PFX_FS || b == PFX_GS)
						seg = b;
					else if (b == PFX_OPSZ)
						pfx[1] = 1'b1;
					else if (b == PFX_ADSZ)
						pfx[2] = 1'b1;
					else begin
						op = b;
						phase = (b == OP_ESCAPE) ? PH_OPCODE2 : plan(PH_MODRM);
					end
					if (phase == PH_PREFIX && count > MAX_PREFIXES) begin
						flags = '0;
						flags[FB_ERROR] = 1'b1;
						phase = PH_DONE;
					end
				end
			endcase
			if (phase != PH_DONE)
				return 0;
			r.inst_length = count;
			r.field_flags = flags;
			r.rep_prefix = rep;
			r.segment_prefix = seg;
			r.other_prefixes = pfx;
			r.primary_opcode = op;
			r.secondary_opcode = op2;
			r.modrm_byte = modrm;
			r.sib_byte = sib;
			r.displacement = disp;
			r.immediate = imm;
			if (flags[FB_ERROR])
				overflow_insts++;
			if (int'(count) > longest)
				longest = int'(count);
			clear();
			return 1;
		endfunction

		function void note_byte(input logic [7:0] b);
			ild_result_t r;
			if (step(b, r))
				expected_q.push_back(r);
		endfunction

		function void check_field(input string name, input logic [63:0] e, input logic [63:0] a);
			if (e === a)
				return;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, e, a);
		endfunction

		function void check_result(input ild_result_t got);
			ild_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: instruction result with nothing expected", $realtime);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			check_field("inst_length", 64'(e.inst_length), 64'(got.inst_length));
			check_field("field_flags", 64'(e.field_flags), 64'(got.field_flags));
			check_field("rep_prefix", 64'(e.rep_prefix), 64'(got.rep_prefix));
			check_field("segment_prefix", 64'(e.segment_prefix), 64'(got.segment_prefix));
			check_field("other_prefixes", 64'(e.other_prefixes), 64'(got.other_prefixes));
			check_field("primary_opcode", 64'(e.primary_opcode), 64'(got.primary_opcode));
			check_field("secondary_opcode", 64'(e.secondary_opcode),
				64'(got.secondary_opcode));
			check_field("modrm_byte", 64'(e.modrm_byte), 64'(got.modrm_byte));
			check_field("sib_byte", 64'(e.sib_byte), 64'(got.sib_byte));
			check_field("displacement", 64'(e.displacement), 64'(got.displacement));
			check_field("immediate", e.immediate, got.immediate);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        code_valid = 1'b0;
	logic        code_ready;
	logic [7:0]  code_byte = 8'h00;
	logic        inst_valid;
	logic        inst_ready = 1'b0;
	logic [4:0]  inst_length;
	logic [7:0]  field_flags;
	logic [7:0]  rep_prefix;
	logic [7:0]  segment_prefix;
	logic [2:0]  other_prefixes;
	logic [7:0]  primary_opcode;
	logic [7:0]  secondary_opcode;
	logic [7:0]  modrm_byte;
	logic [7:0]  sib_byte;
	logic [31:0] displacement;
	logic [63:0] immediate;
	ild_result_t inst_seen;

	ild_scoreboard sb;
	ild_scoreboard lookahead;
	int idle_pct = 0;
	int stall_pct = 0;
	int storm_len = 0;
	int bytes_sent = 0;
	int cycles = 0;

	x86_64_instruction_length_decoder_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.code_valid       (code_valid),
		.code_ready       (code_ready),
		.code_byte        (code_byte),
		.inst_valid       (inst_valid),
		.inst_ready       (inst_ready),
		.inst_length      (inst_length),
		.field_flags      (field_flags),
		.rep_prefix       (rep_prefix),
		.segment_prefix   (segment_prefix),
		.other_prefixes   (other_prefixes),
		.primary_opcode   (primary_opcode),
		.secondary_opcode (secondary_opcode),
		.modrm_byte       (modrm_byte),
		.sib_byte         (sib_byte),
		.displacement     (displacement),
		.immediate        (immediate)
	);

	assign inst_seen = {inst_length, field_flags, rep_prefix, segment_prefix, other_prefixes,
		primary_opcode, secondary_opcode, modrm_byte, sib_byte, displacement, immediate};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && inst_valid && inst_ready)
			sb.check_result(inst_seen);
		inst_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Bias the next byte by where the decode stands, with some pure noise.
	function automatic logic [7:0] pick_code_byte();
		logic [7:0] b;
		int r;
		int c;
		r = $urandom_range(0, 99);
		b = 8'($urandom);
		if (lookahead.phase == PH_PREFIX && lookahead.count == 5'd0)
			storm_len = ($urandom_range(0, 99) < 4) ? $urandom_range(12, 17) : 0;
		if ($urandom_range(0, 99) < 8)
			return b;
		case (lookahead.phase)
			PH_OPCODE2: begin
				if (r < 25)
					b = OP2_IMM32[$urandom_range(0, 3)];
				else if (r < 45)
					b = {2'b00, 3'($urandom), ALU_IMM_ROW};
			end
			PH_MODRM: begin
				if (r < 30)
					b[2:0] = RM_SIB;
				else if (r < 55)
					b[2:0] = RM_DISP32;
			end
			PH_PREFIX: begin
				c = $urandom_range(0, 99);
				if (int'(lookahead.count) < storm_len || r < 20)
					b = PREFIX_SET[$urandom_range(0, 10)];
				else if (c < 15)
					b = OP_ESCAPE;
				else if (c < 25)
					b = OP_RM_A_LO + 8'($urandom_range(0, 15));
				else if (c < 32)
					b = OP_RM_B_LO + 8'($urandom_range(0, 31));
				else if (c < 38)
					b = (c[0]) ? OP_GRP3_B + 8'(c[1]) : OP_GRP4 + 8'(c[1]);
				else if (c < 50)
					b = {2'b00, 3'($urandom), ALU_IMM_ROW};
				else if (c < 60)
					b = (c[0]) ? OP_PUSH_IMM32 : ((c[1]) ? OP_PUSH_IMM8 :
						((c[2]) ? OP_IMUL_IMM8 : OP_GRP1_IMM8));
				else if (c < 72)
					b = OP_MOV_IMM_LO + 8'($urandom_range(0, 7));
			end
			default: ;
		endcase
		return b;
	endfunction

	task automatic push_code(input logic [7:0] b);
		ild_result_t scratch;
		void'(lookahead.step(b, scratch));
		while ($urandom_range(0, 99) < idle_pct) begin
			code_valid <= 1'b0;
			@(posedge clk);
		end
		code_valid <= 1'b1;
		code_byte <= b;
		do @(posedge clk); while (!code_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic drain_results();
		code_valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	initial begin
		logic [7:0] directed_q[$];
		sb = new();
		lookahead = new();
		directed_q = '{8'h90,
			PFX_REPE, PFX_REPNE, PFX_LOCK, PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS,
			PFX_GS, PFX_OPSZ, PFX_ADSZ, PFX_REPNE, PFX_LOCK, PFX_OPSZ, PFX_ADSZ, PFX_CS,
			PFX_REPNE, PFX_GS, PFX_LOCK, PFX_OPSZ, PFX_ADSZ, PFX_ES, PFX_SS, PFX_DS,
			PFX_FS, PFX_REPE, PFX_CS, PFX_LOCK, PFX_OPSZ, PFX_ADSZ, PFX_REPE,
			OP_ESCAPE, 8'h05, 8'h84, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44,
			8'hAA, 8'hBB, 8'hCC, 8'hDD,
			PFX_OPSZ, OP_MOV_IMM_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			OP_MOV_IMM_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			OP_GRP1_IMM8, 8'h45, 8'h7F, 8'h80,
			8'h8B, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04,
			OP_PUSH_IMM8, 8'h00,
			OP_IMUL_IMM8, 8'h7F,
			OP_PUSH_IMM32, 8'h78, 8'h56, 8'h34, 8'h12,
			8'h3D, 8'hEF, 8'hBE, 8'hAD, 8'hDE,
			OP_ESCAPE, OP2_IMM32[2], 8'hC0, 8'h01, 8'h00, 8'h00, 8'h80,
			OP_ESCAPE, 8'h00, 8'h00,
			OP_GRP3_B, 8'h04, 8'h25,
			OP_GRP5, 8'hFF,
			8'h00};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			push_code(directed_q[i]);
		drain_results();

		for (int p = 0; p < 4; p++) begin
			idle_pct = SEND_IDLE_PCT[p];
			stall_pct = RECV_STALL_PCT[p];
			repeat (RANDOM_BYTES_PER_PHASE)
				push_code(pick_code_byte());
			drain_results();
		end

		stall_pct = 0;
		repeat (6) @(posedge clk);

		$display("covered %0d code bytes and %0d instructions (%0d prefix overflows, longest %0d)",
			bytes_sent, sb.checked, sb.overflow_insts, sb.longest);
		$display("idle profiles: none, sender 71%%, receiver 71%%, both 22%%");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results never arrived", sb.mismatches,
				sb.expected_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
